@@ src/pfbm_pkg.sv @@
// ---------------------------------------------------------------------------
// pfbm_pkg: shared types and constants for the pixel format best match block
// Beat payloads, configuration register indexes, selection codes and the
// per-channel shortfall helpers.
// ---------------------------------------------------------------------------
package pfbm_pkg;

  localparam int DEFAULT_MAX_CANDIDATES = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DIST_W      = 10;  // four channels of at most 15*15

  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_RED   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_GREEN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_BLUE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_ALPHA = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_CLASS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_TAG   = 3'd5;

  localparam logic [1:0] HOW_TAG   = 2'd0;
  localparam logic [1:0] HOW_CLOSE = 2'd1;
  localparam logic [1:0] HOW_WIDE  = 2'd2;

  typedef struct packed {
    logic [3:0]  cand_red_bits;
    logic [3:0]  cand_green_bits;
    logic [3:0]  cand_blue_bits;
    logic [3:0]  cand_alpha_bits;
    logic [1:0]  cand_class;
    logic [1:0]  cand_bytes_less_one;
    logic [31:0] cand_tag;
    logic        last_candidate;
  } cand_t;

  typedef struct packed {
    logic [7:0] chosen_index;
    logic [1:0] how_chosen;
    logic       list_overflow;
  } result_t;

  typedef struct packed {
    logic [3:0]  want_red_bits;
    logic [3:0]  want_green_bits;
    logic [3:0]  want_blue_bits;
    logic [3:0]  want_alpha_bits;
    logic [1:0]  want_class;
    logic [31:0] want_tag;
  } cfg_t;

  // squared shortfall of one channel, zero when the candidate has enough bits
  function automatic logic [DIST_W-1:0] shortfall_sq(input logic [3:0] want,
                                                     input logic [3:0] have);
    logic [3:0] d;
    d = (want > have) ? (want - have) : 4'd0;
    return DIST_W'(d) * DIST_W'(d);
  endfunction

  function automatic logic [3:0] channel_mask(input logic [3:0] r, input logic [3:0] g,
                                              input logic [3:0] b, input logic [3:0] a);
    return {a != 4'd0, b != 4'd0, g != 4'd0, r != 4'd0};
  endfunction

endpackage

@@ src/pfbm_cand_if.sv @@
// ---------------------------------------------------------------------------
// pfbm_cand_if: candidate format channel
// valid/ready handshake carrying one candidate format per beat.
// ---------------------------------------------------------------------------
interface pfbm_cand_if;
  logic           valid;
  logic           ready;
  pfbm_pkg::cand_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/pfbm_result_if.sv @@
// ---------------------------------------------------------------------------
// pfbm_result_if: selection result channel
// valid/ready handshake carrying one chosen candidate per beat.
// ---------------------------------------------------------------------------
interface pfbm_result_if;
  logic             valid;
  logic             ready;
  pfbm_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/pfbm_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// pfbm_cfg_regs: wanted format registers
// Decodes the write port and holds the wanted channel widths, class and tag.
// ---------------------------------------------------------------------------
module pfbm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [pfbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pfbm_pkg::cfg_t                   cfg
);
  import pfbm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WANT_RED:   cfg.want_red_bits   <= cfg_data[3:0];
        CFG_WANT_GREEN: cfg.want_green_bits <= cfg_data[3:0];
        CFG_WANT_BLUE:  cfg.want_blue_bits  <= cfg_data[3:0];
        CFG_WANT_ALPHA: cfg.want_alpha_bits <= cfg_data[3:0];
        CFG_WANT_CLASS: cfg.want_class      <= cfg_data[1:0];
        CFG_WANT_TAG:   cfg.want_tag        <= cfg_data[31:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

@@ src/pfbm_in_stage.sv @@
// ---------------------------------------------------------------------------
// pfbm_in_stage: candidate input register
// Captures one candidate beat and holds it until the tracker takes it.
// ---------------------------------------------------------------------------
module pfbm_in_stage (
  input  logic            clk,
  input  logic            rst,
  pfbm_cand_if.sink       cand,
  input  logic            step,
  output logic            item_valid,
  output pfbm_pkg::cand_t item
);
  import pfbm_pkg::*;

  logic item_valid_next;
  logic load;

  assign cand.ready = !item_valid || step;
  assign load       = cand.valid && cand.ready;

  always_comb begin
    item_valid_next = item_valid;
    if (load) begin
      item_valid_next = 1'b1;
    end else if (step) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= cand.data;
    end
  end

endmodule

@@ src/pfbm_track.sv @@
// ---------------------------------------------------------------------------
// pfbm_track: running best-candidate tracker
// Updates the tag, closest and widest choices from the registered candidate
// and loads the result register on the last candidate of a list.
// ---------------------------------------------------------------------------
module pfbm_track #(
  parameter int MAX_CANDIDATES = pfbm_pkg::DEFAULT_MAX_CANDIDATES
) (
  input  logic            clk,
  input  logic            rst,
  input  pfbm_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  pfbm_pkg::cand_t item,
  output logic            step,
  pfbm_result_if.source   result
);
  import pfbm_pkg::*;

  localparam int POS_W = $clog2(MAX_CANDIDATES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CANDIDATES);

  logic [POS_W-1:0]  position,       position_next;
  logic              tag_found,      tag_found_next;
  logic [7:0]        tag_index,      tag_index_next;
  logic              close_found,    close_found_next;
  logic [7:0]        close_index,    close_index_next;
  logic [DIST_W-1:0] close_distance, close_distance_next;
  logic [1:0]        close_bytes,    close_bytes_next;
  logic [7:0]        wide_index,     wide_index_next;
  logic [1:0]        wide_bytes,     wide_bytes_next;
  logic              overflowed,     overflowed_next;

  logic              out_valid, out_valid_next;
  result_t           out_data;
  result_t           pick;

  logic [POS_W+7:0]  pos_ext;
  logic [7:0]        idx;
  logic              in_range;
  logic [3:0]        wanted;
  logic [3:0]        have;
  logic              qualify;
  logic [DIST_W-1:0] cand_distance;
  logic              close_take;
  logic              wide_take;
  logic              finish;

  // a last beat may not overwrite a result that is still waiting
  assign step   = item_valid && !(item.last_candidate && out_valid && !result.ready);
  assign finish = step && item.last_candidate;

  assign pos_ext  = {8'd0, position};
  assign idx      = pos_ext[7:0];
  assign in_range = position != POS_MAX;

  assign wanted = channel_mask(cfg.want_red_bits, cfg.want_green_bits,
                               cfg.want_blue_bits, cfg.want_alpha_bits);
  assign have   = channel_mask(item.cand_red_bits, item.cand_green_bits,
                               item.cand_blue_bits, item.cand_alpha_bits);
  assign qualify = (item.cand_class == cfg.want_class) && ((have & wanted) == wanted);
  assign cand_distance = shortfall_sq(cfg.want_red_bits,   item.cand_red_bits)
                       + shortfall_sq(cfg.want_green_bits, item.cand_green_bits)
                       + shortfall_sq(cfg.want_blue_bits,  item.cand_blue_bits)
                       + shortfall_sq(cfg.want_alpha_bits, item.cand_alpha_bits);

  assign close_take = qualify && (!close_found || cand_distance < close_distance ||
                      (cand_distance == close_distance &&
                       item.cand_bytes_less_one < close_bytes));
  assign wide_take  = (position == '0) || (item.cand_bytes_less_one > wide_bytes);

  always_comb begin
    position_next       = position;
    tag_found_next      = tag_found;
    tag_index_next      = tag_index;
    close_found_next    = close_found;
    close_index_next    = close_index;
    close_distance_next = close_distance;
    close_bytes_next    = close_bytes;
    wide_index_next     = wide_index;
    wide_bytes_next     = wide_bytes;
    overflowed_next     = overflowed;

    if (step) begin
      if (!in_range) begin
        overflowed_next = 1'b1;
      end else begin
        if (!tag_found && cfg.want_tag != 32'd0 && item.cand_tag == cfg.want_tag) begin
          tag_found_next = 1'b1;
          tag_index_next = idx;
        end
        if (close_take) begin
          close_found_next    = 1'b1;
          close_index_next    = idx;
          close_distance_next = cand_distance;
          close_bytes_next    = item.cand_bytes_less_one;
        end
        if (wide_take) begin
          wide_index_next = idx;
          wide_bytes_next = item.cand_bytes_less_one;
        end
        position_next = position + 1'b1;
      end
    end

    if (tag_found_next) begin
      pick.chosen_index = tag_index_next;
      pick.how_chosen   = HOW_TAG;
    end else if (close_found_next) begin
      pick.chosen_index = close_index_next;
      pick.how_chosen   = HOW_CLOSE;
    end else begin
      pick.chosen_index = wide_index_next;
      pick.how_chosen   = HOW_WIDE;
    end
    pick.list_overflow = overflowed_next;

    out_valid_next = out_valid && !result.ready;
    if (finish) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      position       <= '0;
      tag_found      <= 1'b0;
      tag_index      <= '0;
      close_found    <= 1'b0;
      close_index    <= '0;
      close_distance <= '0;
      close_bytes    <= '0;
      wide_index     <= '0;
      wide_bytes     <= '0;
      overflowed     <= 1'b0;
    end else begin
      position       <= position_next;
      tag_found      <= tag_found_next;
      tag_index      <= tag_index_next;
      close_found    <= close_found_next;
      close_index    <= close_index_next;
      close_distance <= close_distance_next;
      close_bytes    <= close_bytes_next;
      wide_index     <= wide_index_next;
      wide_bytes     <= wide_bytes_next;
      overflowed     <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= pick;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    finish |=> (position == '0 && !tag_found && !close_found && !overflowed))
    else $error("list state not cleared after last candidate");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_MAX)
    else $error("position beyond candidate limit");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(finish))
    else $error("result appeared without a last candidate");

  a_how_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.how_chosen == HOW_TAG || out_data.how_chosen == HOW_CLOSE ||
                   out_data.how_chosen == HOW_WIDE))
    else $error("undefined selection code");

  a_overflow_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> position == POS_MAX)
    else $error("overflow flagged below candidate limit");
`endif

endmodule

@@ src/pixel_format_best_match.sv @@
// ---------------------------------------------------------------------------
// pixel_format_best_match: pick the best pixel format from a candidate list
// Tracks tag match, least channel shortfall and widest format over a stream
// of candidates and reports the choice on the last one of each list.
// ---------------------------------------------------------------------------
//   port       dir   handshake          beat contents
//   cand       in    valid/ready        one candidate format, last mark
//   result     out   valid/ready        chosen index, how chosen, overflow
//   cfg_*      in    cfg_wr_en          register index, 32-bit write data
//
// One candidate per cycle: an input register, then the tracker logic that
// loads the result register. A result is valid once its last beat has left
// the input register and loaded the result register. Reset (rst, synchronous)
// clears the list state and the wanted format. Only a last beat stalls, held
// in the input register while a previous result still waits, and the input
// stalls with it; other beats keep flowing while a result waits.
// ---------------------------------------------------------------------------
module pixel_format_best_match #(
  parameter int MAX_CANDIDATES = pfbm_pkg::DEFAULT_MAX_CANDIDATES
) (
  input  logic                             clk,
  input  logic                             rst,
  pfbm_cand_if.sink                        cand,
  pfbm_result_if.source                    result,
  input  logic                             cfg_wr_en,
  input  logic [pfbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pfbm_pkg::*;

  cfg_t  cfg;
  cand_t item;
  logic  item_valid;
  logic  step;

  pfbm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfbm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cand       (cand),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  pfbm_track #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .step       (step),
    .result     (result)
  );

endmodule
